/* sv/escaped_string_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Escaped string decoder assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_STRING_DECODER_DEFINES_SVH
`define ESCAPED_STRING_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every edge out of reset
`define ESD_ASSERT(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("esd assertion failed");

// same-cycle implication
`define ESD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esd implication failed");

// next-cycle implication
`define ESD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esd next-cycle check failed");

`else

`define ESD_ASSERT(name, expr)
`define ESD_ASSERT_IMP(name, ante, cons)
`define ESD_ASSERT_NXT(name, ante, cons)

`endif

`endif

/* sv/esd_pkg.sv */
// ----------------------------------------------------------------------------
// Escaped string decoder package
// Types, codes and character constants of the escaped string decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int MAX_BYTES   = 256;
    localparam int COUNT_W     = 9;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_OCT  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_FAIL  = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic REG_OPEN_QUOTE  = 1'b0;
    localparam logic REG_CLOSE_QUOTE = 1'b1;

    localparam logic [7:0] OPEN_QUOTE_RST  = 8'd34;
    localparam logic [7:0] CLOSE_QUOTE_RST = 8'd34;

    localparam logic [7:0] CH_EOL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic [COUNT_W-1:0] count;
        logic               ovf;
        logic               last;
    } result_t;

    // hex digit value; valid flag in bit 4
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

/* sv/escaped_string_decoder.sv */
// ----------------------------------------------------------------------------
// Escaped string decoder
// Decodes one quoted C-style escaped string per line, one character a word.
// ----------------------------------------------------------------------------
// One character word is taken per cycle into an input register while in_stall
// is low, decoded in a single combinational pass against the phase, escape
// accumulator and byte counter, and its zero, one or two result words are
// pushed into a four-entry result queue. The input side takes a new word every
// cycle while the queue has room for two results; the output side drains one
// result per cycle while out_stall is low, so the sustained rate is then one
// character per cycle for characters that give at most one result. The first
// result word of a character is valid once it is in the queue. open_quote and
// close_quote must be written only while idle; the block does not enforce it.
`include "escaped_string_decoder_defines.svh"

module escaped_string_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  out_byte,
    output logic [8:0]  byte_count,
    output logic        overflow,
    output logic        last
);

    localparam logic [esd_pkg::COUNT_W-1:0] CNT_MAX =
        esd_pkg::COUNT_W'(esd_pkg::MAX_BYTES);
    localparam logic [esd_pkg::FIFO_CW-1:0] ROOM_LIMIT =
        esd_pkg::FIFO_CW'(esd_pkg::FIFO_DEPTH - 2);

    logic [7:0] open_quote_reg;
    logic [7:0] close_quote_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;

    esd_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                   acc_reg, acc_next;
    logic [esd_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                         sat_reg, sat_next;

    esd_pkg::result_t             fifo_mem [esd_pkg::FIFO_DEPTH];
    logic [esd_pkg::FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [esd_pkg::FIFO_CW-1:0]  fcount_reg, fcount_next;

    logic advance;
    logic pop;

    esd_pkg::result_t r0, r1;
    logic             v0, v1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_quote_reg  <= esd_pkg::OPEN_QUOTE_RST;
            close_quote_reg <= esd_pkg::CLOSE_QUOTE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                esd_pkg::REG_OPEN_QUOTE:  open_quote_reg  <= cfg_data;
                esd_pkg::REG_CLOSE_QUOTE: close_quote_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance  = s1_valid_reg && (fcount_reg <= ROOM_LIMIT);
    assign in_stall = s1_valid_reg && !advance;
    assign out_valid = (fcount_reg != '0);
    assign pop       = out_valid && !out_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_char_reg <= char_code;
    end

    // decode pass
    logic [7:0]                  c;
    logic [4:0]                  hexd;
    logic                        oct_ok;
    logic [esd_pkg::COUNT_W-1:0] bump1_cnt, str_cnt, bump2_cnt;
    logic                        bump1_sat, str_sat, bump2_sat;
    logic                        hexoct;
    logic                        str_v;
    esd_pkg::result_t            str_r;
    esd_pkg::phase_t             str_phase;
    logic [esd_pkg::COUNT_W-1:0] str_cnt_out;
    logic                        str_sat_out;
    logic [7:0]                  esc_byte;

    always_comb
    begin
        c      = s1_char_reg;
        hexd   = esd_pkg::hex_digit(c);
        oct_ok = (c >= 8'h30) && (c <= 8'h37);
        hexoct = (phase_reg == esd_pkg::PH_HEX) || (phase_reg == esd_pkg::PH_OCT);

        bump1_cnt = (cnt_reg < CNT_MAX) ? cnt_reg + esd_pkg::COUNT_W'(1) : cnt_reg;
        bump1_sat = sat_reg | (cnt_reg >= CNT_MAX);

        // a numeric escape flush counts its byte before the terminator
        str_cnt   = hexoct ? bump1_cnt : cnt_reg;
        str_sat   = hexoct ? bump1_sat : sat_reg;
        bump2_cnt = (str_cnt < CNT_MAX) ? str_cnt + esd_pkg::COUNT_W'(1) : str_cnt;
        bump2_sat = str_sat | (str_cnt >= CNT_MAX);

        // ordinary character inside the string
        str_v       = 1'b1;
        str_r       = '0;
        str_phase   = esd_pkg::PH_STR;
        str_cnt_out = str_cnt;
        str_sat_out = str_sat;
        if (c == close_quote_reg)
        begin
            str_r.kind  = esd_pkg::KIND_CLOSE;
            str_r.count = str_cnt;
            str_r.ovf   = str_sat;
            str_phase   = esd_pkg::PH_IDLE;
        end
        else if (c == esd_pkg::CH_EOL)
        begin
            str_r.kind = esd_pkg::KIND_FAIL;
            str_phase  = esd_pkg::PH_IDLE;
        end
        else if (c == esd_pkg::CH_BSL)
        begin
            str_v     = 1'b0;
            str_phase = esd_pkg::PH_ESC;
        end
        else
        begin
            str_r.kind  = esd_pkg::KIND_BYTE;
            str_r.data  = c;
            str_cnt_out = bump2_cnt;
            str_sat_out = bump2_sat;
        end

        unique case (c)
            esd_pkg::CH_A: esc_byte = 8'd7;
            esd_pkg::CH_B: esc_byte = 8'd8;
            esd_pkg::CH_F: esc_byte = 8'd12;
            esd_pkg::CH_N: esc_byte = 8'd10;
            esd_pkg::CH_R: esc_byte = 8'd13;
            esd_pkg::CH_T: esc_byte = 8'd9;
            esd_pkg::CH_V: esc_byte = 8'd11;
            default:       esc_byte = c;
        endcase

        v0         = 1'b0;
        v1         = 1'b0;
        r0         = '0;
        r1         = '0;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;

        unique case (phase_reg) inside
            esd_pkg::PH_IDLE:
            begin
                if (c == esd_pkg::CH_SPACE || c == esd_pkg::CH_TAB)
                begin
                    phase_next = esd_pkg::PH_IDLE;
                end
                else if (c != esd_pkg::CH_EOL && c == open_quote_reg)
                begin
                    phase_next = esd_pkg::PH_STR;
                    acc_next   = '0;
                    cnt_next   = '0;
                    sat_next   = 1'b0;
                end
                else
                begin
                    v0      = 1'b1;
                    r0.kind = esd_pkg::KIND_FAIL;
                end
            end
            esd_pkg::PH_STR:
            begin
                v0         = str_v;
                r0         = str_r;
                phase_next = str_phase;
                cnt_next   = str_cnt_out;
                sat_next   = str_sat_out;
            end
            esd_pkg::PH_ESC:
            begin
                phase_next = esd_pkg::PH_STR;
                if (c == esd_pkg::CH_EOL)
                begin
                    v0         = 1'b1;
                    r0.kind    = esd_pkg::KIND_FAIL;
                    phase_next = esd_pkg::PH_IDLE;
                end
                else if (c == esd_pkg::CH_X)
                begin
                    acc_next   = '0;
                    phase_next = esd_pkg::PH_HEX;
                end
                else if (c == esd_pkg::CH_ZERO)
                begin
                    acc_next   = '0;
                    phase_next = esd_pkg::PH_OCT;
                end
                else
                begin
                    v0       = 1'b1;
                    r0.kind  = esd_pkg::KIND_BYTE;
                    r0.data  = esc_byte;
                    cnt_next = bump1_cnt;
                    sat_next = bump1_sat;
                end
            end
            esd_pkg::PH_HEX,
            esd_pkg::PH_OCT:
            begin
                if (phase_reg == esd_pkg::PH_HEX && hexd[4])
                begin
                    acc_next = {acc_reg[3:0], hexd[3:0]};
                end
                else if (phase_reg == esd_pkg::PH_OCT && oct_ok)
                begin
                    acc_next = {acc_reg[4:0], c[2:0]};
                end
                else
                begin
                    // flush the accumulated byte, then treat c as a string char
                    v0         = 1'b1;
                    r0.kind    = esd_pkg::KIND_BYTE;
                    r0.data    = acc_reg;
                    v1         = str_v;
                    r1         = str_r;
                    acc_next   = '0;
                    phase_next = str_phase;
                    cnt_next   = str_cnt_out;
                    sat_next   = str_sat_out;
                end
            end
            default:
            begin
                phase_next = esd_pkg::PH_IDLE;
            end
        endcase

        r0.last = v0 && !v1;
        r1.last = v1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= esd_pkg::PH_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
        end
    end

    // result queue
    always_comb
    begin
        fcount_next = fcount_reg - esd_pkg::FIFO_CW'(pop);
        if (advance)
            fcount_next = fcount_next + esd_pkg::FIFO_CW'(v0) + esd_pkg::FIFO_CW'(v1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcount_reg <= '0;
        end
        else
        begin
            fcount_reg <= fcount_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + esd_pkg::FIFO_AW'(1);
            if (advance)
                wr_ptr_reg <= wr_ptr_reg + esd_pkg::FIFO_AW'(v0) + esd_pkg::FIFO_AW'(v1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && v0)
            fifo_mem[wr_ptr_reg] <= r0;
        if (advance && v1)
            fifo_mem[wr_ptr_reg + esd_pkg::FIFO_AW'(1)] <= r1;
    end

    assign result_kind = fifo_mem[rd_ptr_reg].kind;
    assign out_byte    = fifo_mem[rd_ptr_reg].data;
    assign byte_count  = fifo_mem[rd_ptr_reg].count;
    assign overflow    = fifo_mem[rd_ptr_reg].ovf;
    assign last        = fifo_mem[rd_ptr_reg].last;

    // checks
    logic head_close;
    logic end_word;

    assign head_close = (result_kind == esd_pkg::KIND_CLOSE);
    assign end_word   = (v0 && r0.kind != esd_pkg::KIND_BYTE) ||
                        (v1 && r1.kind != esd_pkg::KIND_BYTE);

    `ESD_ASSERT(a_fifo_bound, fcount_reg <= esd_pkg::FIFO_CW'(esd_pkg::FIFO_DEPTH))
    `ESD_ASSERT_IMP(a_count_only_on_close, out_valid && !head_close, byte_count == '0 && !overflow)
    `ESD_ASSERT_NXT(a_idle_after_end, advance && end_word, phase_reg == esd_pkg::PH_IDLE)
    `ESD_ASSERT_IMP(a_second_needs_first, v1, v0 && r0.kind == esd_pkg::KIND_BYTE)

endmodule

/* dv/escaped_string_decoder_test.sv */
// ----------------------------------------------------------------------------
// Escaped string decoder testbench
// Drives character words through the decoder with random idle and stall,
// predicts every result word in the bench and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module escaped_string_decoder_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [7:0]     ch;
        logic           typed;
        esd_pkg::kind_t kind;
        logic [7:0]     data;
    } stim_row_t;

    // typed rows carry their single result word; the rest go to the predictor
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{esd_pkg::CH_EOL,          1'b1, esd_pkg::KIND_FAIL, 8'h00},
        '{esd_pkg::CH_SPACE,        1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_TAB,          1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'hFF,                    1'b1, esd_pkg::KIND_FAIL, 8'h00},
        '{esd_pkg::OPEN_QUOTE_RST,  1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'hFF,                    1'b1, esd_pkg::KIND_BYTE, 8'hFF},
        '{esd_pkg::CH_BSL,          1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_A,            1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_BSL,          1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CLOSE_QUOTE_RST, 1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_BSL,          1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_X,            1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'h46,                    1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'h66,                    1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'h67,                    1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_BSL,          1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_ZERO,         1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'h37,                    1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'h37,                    1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{8'h37,                    1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CLOSE_QUOTE_RST, 1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::OPEN_QUOTE_RST,  1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_BSL,          1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_X,            1'b0, esd_pkg::KIND_BYTE, 8'h00},
        '{esd_pkg::CH_EOL,          1'b0, esd_pkg::KIND_BYTE, 8'h00}
    };

    localparam logic [7:0] ESC_LETTERS [7] = '{
        esd_pkg::CH_A, esd_pkg::CH_B, esd_pkg::CH_F, esd_pkg::CH_N,
        esd_pkg::CH_R, esd_pkg::CH_T, esd_pkg::CH_V
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_code;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [8:0] byte_count;
    logic       overflow;
    logic       last;

    // decoder state as predicted
    esd_pkg::phase_t ph = esd_pkg::PH_IDLE;
    logic [7:0]      acc = '0;
    logic [8:0]      nbytes = '0;
    logic            sat = 1'b0;
    logic [7:0]      open_q = esd_pkg::OPEN_QUOTE_RST;
    logic [7:0]      close_q = esd_pkg::CLOSE_QUOTE_RST;

    esd_pkg::result_t char_words[$];
    esd_pkg::result_t expected_words[$];
    esd_pkg::result_t got_word;
    esd_pkg::result_t want_word;

    logic             row_typed = 1'b0;
    esd_pkg::result_t row_typed_word = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold_req = 0;
    int phase_items = 0;
    int mismatches = 0;
    int cycle_count = 0;

    escaped_string_decoder DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void push_word(input esd_pkg::kind_t k, input logic [7:0] b,
                                      input logic [8:0] n, input logic o);
        esd_pkg::result_t w;
        w.kind  = k;
        w.data  = b;
        w.count = n;
        w.ovf   = o;
        w.last  = 1'b0;
        char_words.push_back(w);
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        if (nbytes < esd_pkg::MAX_BYTES)
            nbytes = nbytes + 9'd1;
        else
            sat = 1'b1;
        push_word(esd_pkg::KIND_BYTE, b, 9'd0, 1'b0);
    endfunction

    function automatic int digit_value(input logic [7:0] c, input int radix);
        int d;
        if (c >= 8'h30 && c <= 8'h39)
            d = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h5A)
            d = c - 8'h41 + 10;
        else if (c >= 8'h61 && c <= 8'h7A)
            d = c - 8'h61 + 10;
        else
            d = radix;
        return (d < radix) ? d : -1;
    endfunction

    // close quote wins over end of line and backslash
    function automatic void string_char(input logic [7:0] c);
        if (c == close_q)
        begin
            push_word(esd_pkg::KIND_CLOSE, 8'd0, nbytes, sat);
            ph = esd_pkg::PH_IDLE;
        end
        else if (c == esd_pkg::CH_EOL)
        begin
            push_word(esd_pkg::KIND_FAIL, 8'd0, 9'd0, 1'b0);
            ph = esd_pkg::PH_IDLE;
        end
        else if (c == esd_pkg::CH_BSL)
            ph = esd_pkg::PH_ESC;
        else
            emit_data(c);
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        int               radix;
        int               d;
        esd_pkg::result_t w;
        char_words.delete();
        case (ph) inside
            esd_pkg::PH_IDLE:
            begin
                if (c == esd_pkg::CH_SPACE || c == esd_pkg::CH_TAB)
                    ;
                else if (c != esd_pkg::CH_EOL && c == open_q)
                begin
                    ph = esd_pkg::PH_STR;
                    acc = '0;
                    nbytes = '0;
                    sat = 1'b0;
                end
                else
                    push_word(esd_pkg::KIND_FAIL, 8'd0, 9'd0, 1'b0);
            end
            esd_pkg::PH_STR:
                string_char(c);
            esd_pkg::PH_ESC:
            begin
                ph = esd_pkg::PH_STR;
                case (c)
                    esd_pkg::CH_EOL:
                    begin
                        push_word(esd_pkg::KIND_FAIL, 8'd0, 9'd0, 1'b0);
                        ph = esd_pkg::PH_IDLE;
                    end
                    esd_pkg::CH_A: emit_data(8'd7);
                    esd_pkg::CH_B: emit_data(8'd8);
                    esd_pkg::CH_F: emit_data(8'd12);
                    esd_pkg::CH_N: emit_data(8'd10);
                    esd_pkg::CH_R: emit_data(8'd13);
                    esd_pkg::CH_T: emit_data(8'd9);
                    esd_pkg::CH_V: emit_data(8'd11);
                    esd_pkg::CH_X:
                    begin
                        acc = '0;
                        ph = esd_pkg::PH_HEX;
                    end
                    esd_pkg::CH_ZERO:
                    begin
                        acc = '0;
                        ph = esd_pkg::PH_OCT;
                    end
                    default: emit_data(c);
                endcase
            end
            esd_pkg::PH_HEX, esd_pkg::PH_OCT:
            begin
                radix = (ph == esd_pkg::PH_HEX) ? 16 : 8;
                d = digit_value(c, radix);
                if (d >= 0)
                    acc = 8'(acc * radix + d);
                else
                begin
                    // run ends: accumulated byte, then the char as a string char
                    emit_data(acc);
                    acc = '0;
                    ph = esd_pkg::PH_STR;
                    string_char(c);
                end
            end
            default:
                ph = esd_pkg::PH_IDLE;
        endcase
        if (char_words.size() > 0)
        begin
            w = char_words[char_words.size() - 1];
            w.last = 1'b1;
            char_words[char_words.size() - 1] = w;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph = esd_pkg::PH_IDLE;
            acc = '0;
            nbytes = '0;
            sat = 1'b0;
            open_q = esd_pkg::OPEN_QUOTE_RST;
            close_q = esd_pkg::CLOSE_QUOTE_RST;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    esd_pkg::REG_OPEN_QUOTE:  open_q = cfg_data;
                    esd_pkg::REG_CLOSE_QUOTE: close_q = cfg_data;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                decode_char(char_code);
                if (row_typed)
                begin
                    char_words.delete();
                    char_words.push_back(row_typed_word);
                end
                foreach (char_words[i])
                    expected_words.push_back(char_words[i]);
            end
            if (out_valid && !out_stall)
            begin
                got_word.kind  = esd_pkg::kind_t'(result_kind);
                got_word.data  = out_byte;
                got_word.count = byte_count;
                got_word.ovf   = overflow;
                got_word.last  = last;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: unexpected word kind=%0d byte=%02h ",
                                 $time, got_word.kind, got_word.data,
                                 "count=%0d ovf=%0b last=%0b",
                                 got_word.count, got_word.ovf, got_word.last);
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (got_word !== want_word)
                    begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT)
                            $display("%0t: expected kind=%0d byte=%02h ",
                                     $time, want_word.kind, want_word.data,
                                     "count=%0d ovf=%0b last=%0b, ",
                                     want_word.count, want_word.ovf, want_word.last,
                                     "got kind=%0d byte=%02h ",
                                     got_word.kind, got_word.data,
                                     "count=%0d ovf=%0b last=%0b",
                                     got_word.count, got_word.ovf, got_word.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold_req != 0)
            begin
                hold_left = recv_hold_req;
                recv_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic counted = 1'b1,
                             input logic typed = 1'b0,
                             input esd_pkg::result_t typed_word = '0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        row_typed = typed;
        row_typed_word = typed_word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (counted)
            phase_items++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] oq, input logic [7:0] cq,
                             input int s_pct, input int r_pct);
        settle();
        write_reg(esd_pkg::REG_OPEN_QUOTE, oq);
        write_reg(esd_pkg::REG_CLOSE_QUOTE, cq);
        cfg_we <= 1'b0;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == close_q || c == esd_pkg::CH_BSL);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(21);
        if (r < 10)
            return esd_pkg::CH_ZERO + 8'(r);
        else if (r < 16)
            return 8'h61 + 8'(r - 10);
        else
            return 8'h41 + 8'(r - 16);
    endfunction

    task automatic send_element();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            send_char(plain_char());
        else
        begin
            send_char(esd_pkg::CH_BSL);
            if (pick < 65)
                send_char(ESC_LETTERS[$urandom_range(6)]);
            else if (pick < 77)
            begin
                send_char(esd_pkg::CH_X);
                repeat ($urandom_range(3)) send_char(hex_char());
            end
            else if (pick < 87)
            begin
                send_char(esd_pkg::CH_ZERO);
                repeat ($urandom_range(4))
                    send_char(esd_pkg::CH_ZERO + 8'($urandom_range(7)));
            end
            else
                send_char(8'($urandom_range(1, 255)));
        end
    endtask

    // one source line: mostly a quoted string, sometimes noise or a broken end
    task automatic send_line();
        int pick;
        repeat ($urandom_range(2))
            send_char($urandom_range(1) ? esd_pkg::CH_SPACE : esd_pkg::CH_TAB, 1'b0);
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
        else
        begin
            send_char(open_q);
            repeat (($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(8))
                send_element();
            pick = $urandom_range(99);
            if (pick < 75)
                send_char(close_q);
            else if (pick < 85)
                send_char(esd_pkg::CH_EOL);
            else if (pick < 92)
            begin
                send_char(esd_pkg::CH_BSL);
                send_char(esd_pkg::CH_EOL);
            end
            else
            begin
                send_char(esd_pkg::CH_BSL);
                send_char($urandom_range(1) ? esd_pkg::CH_X : esd_pkg::CH_ZERO);
                repeat ($urandom_range(2))
                    send_char(esd_pkg::CH_ZERO + 8'($urandom_range(7)));
                send_char(esd_pkg::CH_EOL);
            end
        end
    endtask

    // end of line always leaves the decoder idle
    task automatic random_lines(input int budget);
        phase_items = 0;
        while (phase_items < budget)
            send_line();
        send_char(esd_pkg::CH_EOL);
    endtask

    task automatic long_string(input int n);
        send_char(open_q);
        repeat (n) send_char(plain_char());
        send_char(close_q);
    endtask

    initial
    begin
        esd_pkg::result_t w;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = esd_pkg::REG_OPEN_QUOTE;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        char_code = esd_pkg::CH_EOL;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            w.kind  = DIRECTED_ROWS[i].kind;
            w.data  = DIRECTED_ROWS[i].data;
            w.count = 9'd0;
            w.ovf   = 1'b0;
            w.last  = 1'b1;
            send_char(DIRECTED_ROWS[i].ch, 1'b1, DIRECTED_ROWS[i].typed, w);
        end

        configure(8'h27, 8'h27, 0, 0);
        random_lines(110);
        configure(8'hFF, esd_pkg::CH_EOL, 63, 0);
        random_lines(110);
        configure(esd_pkg::CH_EOL, 8'hFF, 0, 63);
        random_lines(40);
        // open quote that is also white space: strings never open
        configure(esd_pkg::CH_SPACE, esd_pkg::CH_TAB, 9, 9);
        random_lines(30);
        configure(8'h22, 8'h22, 9, 9);
        random_lines(50);
        long_string(esd_pkg::MAX_BYTES);
        long_string(esd_pkg::MAX_BYTES + 2);

        configure(8'h3C, 8'h3E, 0, 63);
        // long receiver hold while words keep coming: fills the result queue
        recv_hold_req = 80;
        long_string(24);
        settle();
        random_lines(90);

        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
